// ===== rtl/core/olist_pkg.sv =====
// olist_pkg: shared widths, request/status codes and controller-datapath
// command and status types for the ordered list engine.
// No dependencies.
`default_nettype none

package olist_pkg;

    localparam int KIND_W      = 3;
    localparam int VALUE_IN_W  = 32;
    localparam int POS_W       = 8;
    localparam int STATUS_W    = 2;
    localparam int ENTRIES_W   = 6;
    localparam int POS_CMP_W   = POS_W + 1;

    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 40;
    localparam int M_PAD_W     = M_TDATA_W - ENTRIES_W - VALUE_IN_W;

    localparam int DEF_CAPACITY    = 32;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INS_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INS_AT    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DEL_FRONT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DEL_BACK  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DEL_AT    = 3'd5;
    localparam logic [KIND_W-1:0] KIND_TRAVERSE  = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_COUNT,
        PTR_TARGET,
        PTR_INC,
        PTR_DEC
    } t_ptr_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef enum logic [1:0] {
        RD_PTR,
        RD_PTR_DEC,
        RD_PTR_INC
    } t_rd_sel;

    typedef enum logic {
        WR_SRC_VALUE,
        WR_SRC_RAM
    } t_wr_src;

    typedef enum logic [1:0] {
        OUT_SRC_VALUE,
        OUT_SRC_RAM,
        OUT_SRC_SAVED
    } t_out_src;

    typedef struct packed {
        logic                load;
        t_ptr_op             ptr_op;
        t_cnt_op             cnt_op;
        logic                rd_en;
        t_rd_sel             rd_sel;
        logic                wr_en;
        t_wr_src             wr_src;
        logic                save_victim;
        logic                emit;
        logic [STATUS_W-1:0] emit_status;
        t_out_src            emit_src;
        logic                emit_last;
    } t_dp_cmd;

    typedef struct packed {
        logic is_ins;
        logic is_del;
        logic is_trav;
        logic pos_kind;
        logic full;
        logic empty;
        logic ins_pos_bad;
        logic del_pos_bad;
        logic ptr_at_tgt;
        logic ptr_last;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/core/olist_ram.sv =====
// olist_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
`default_nettype none

module olist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/olist_ctrl.sv =====
// olist_ctrl: request sequencer for the ordered list engine.
// Depends on olist_pkg; drives olist_dp through t_dp_cmd / t_dp_stat.
`default_nettype none

module olist_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire olist_pkg::t_dp_stat i_stat,
    output logic                    o_ready,
    output olist_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_UP_CHK,
        S_UP_WR,
        S_DN_RD,
        S_DN_SAVE,
        S_DN_CHK,
        S_DN_WR,
        S_TR_RD,
        S_TR_EMIT,
        S_EMIT
    } t_state;

    t_state                        r_state, n_state;
    logic [olist_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    olist_pkg::t_out_src           r_res_src, n_res_src;

    always_comb begin
        n_state      = r_state;
        n_res_status = r_res_status;
        n_res_src    = r_res_src;
        o_ready      = 1'b0;

        o_cmd             = '0;
        o_cmd.ptr_op      = olist_pkg::PTR_HOLD;
        o_cmd.cnt_op      = olist_pkg::CNT_HOLD;
        o_cmd.rd_sel      = olist_pkg::RD_PTR;
        o_cmd.wr_src      = olist_pkg::WR_SRC_VALUE;
        o_cmd.emit_status = olist_pkg::ST_OK;
        o_cmd.emit_src    = olist_pkg::OUT_SRC_VALUE;

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end

            S_DECODE: begin
                n_res_src = olist_pkg::OUT_SRC_VALUE;
                n_state   = S_EMIT;
                if (i_stat.is_ins) begin
                    if (i_stat.full) begin
                        n_res_status = olist_pkg::ST_FULL;
                    end else if (i_stat.pos_kind && i_stat.ins_pos_bad) begin
                        n_res_status = olist_pkg::ST_INVALID;
                    end else begin
                        o_cmd.ptr_op = olist_pkg::PTR_COUNT;
                        n_state      = S_UP_CHK;
                    end
                end else if (i_stat.is_del) begin
                    if (i_stat.empty) begin
                        n_res_status = olist_pkg::ST_EMPTY;
                    end else if (i_stat.pos_kind && i_stat.del_pos_bad) begin
                        n_res_status = olist_pkg::ST_INVALID;
                    end else begin
                        o_cmd.ptr_op = olist_pkg::PTR_TARGET;
                        n_state      = S_DN_RD;
                    end
                end else if (i_stat.is_trav) begin
                    if (i_stat.empty) begin
                        n_res_status = olist_pkg::ST_EMPTY;
                    end else begin
                        o_cmd.ptr_op = olist_pkg::PTR_ZERO;
                        n_state      = S_TR_RD;
                    end
                end else begin
                    n_res_status = olist_pkg::ST_INVALID;
                end
            end

            S_UP_CHK: begin
                if (i_stat.ptr_at_tgt) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_src = olist_pkg::WR_SRC_VALUE;
                    o_cmd.cnt_op = olist_pkg::CNT_INC;
                    n_res_status = olist_pkg::ST_OK;
                    n_res_src    = olist_pkg::OUT_SRC_VALUE;
                    n_state      = S_EMIT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = olist_pkg::RD_PTR_DEC;
                    n_state      = S_UP_WR;
                end
            end

            S_UP_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_src = olist_pkg::WR_SRC_RAM;
                o_cmd.ptr_op = olist_pkg::PTR_DEC;
                n_state      = S_UP_CHK;
            end

            S_DN_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = olist_pkg::RD_PTR;
                n_state      = S_DN_SAVE;
            end

            S_DN_SAVE: begin
                o_cmd.save_victim = 1'b1;
                n_state           = S_DN_CHK;
            end

            S_DN_CHK: begin
                if (i_stat.ptr_last) begin
                    o_cmd.cnt_op = olist_pkg::CNT_DEC;
                    n_res_status = olist_pkg::ST_OK;
                    n_res_src    = olist_pkg::OUT_SRC_SAVED;
                    n_state      = S_EMIT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = olist_pkg::RD_PTR_INC;
                    n_state      = S_DN_WR;
                end
            end

            S_DN_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_src = olist_pkg::WR_SRC_RAM;
                o_cmd.ptr_op = olist_pkg::PTR_INC;
                n_state      = S_DN_CHK;
            end

            S_TR_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = olist_pkg::RD_PTR;
                n_state      = S_TR_EMIT;
            end

            S_TR_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = olist_pkg::ST_OK;
                    o_cmd.emit_src    = olist_pkg::OUT_SRC_RAM;
                    o_cmd.emit_last   = i_stat.ptr_last;
                    if (i_stat.ptr_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.ptr_op = olist_pkg::PTR_INC;
                        n_state      = S_TR_RD;
                    end
                end
            end

            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = r_res_status;
                    o_cmd.emit_src    = r_res_src;
                    o_cmd.emit_last   = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_res_status <= olist_pkg::ST_OK;
            r_res_src    <= olist_pkg::OUT_SRC_VALUE;
        end else begin
            r_state      <= n_state;
            r_res_status <= n_res_status;
            r_res_src    <= n_res_src;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/olist_dp.sv =====
// olist_dp: list datapath - request latch, entry count, shift pointer,
// value RAM and output beat register. Depends on olist_pkg and olist_ram.
`default_nettype none

module olist_dp #(
    parameter int CAPACITY    = olist_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = olist_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire olist_pkg::t_dp_cmd                    i_cmd,
    input  wire logic        [olist_pkg::KIND_W-1:0]   i_kind,
    input  wire logic signed [olist_pkg::VALUE_IN_W-1:0] i_value,
    input  wire logic        [olist_pkg::POS_W-1:0]    i_pos,
    input  wire logic                                  i_m_tready,
    output olist_pkg::t_dp_stat                        o_stat,
    output logic                                       o_m_tvalid,
    output logic        [olist_pkg::STATUS_W-1:0]      o_status,
    output logic signed [olist_pkg::VALUE_IN_W-1:0]    o_item_value,
    output logic                                       o_last,
    output logic        [olist_pkg::ENTRIES_W-1:0]     o_entries
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);
    localparam logic [olist_pkg::POS_W-1:0] ONE_POS = olist_pkg::POS_W'(1);
    localparam logic [olist_pkg::POS_CMP_W-1:0] ONE_CMP = olist_pkg::POS_CMP_W'(1);

    logic        [olist_pkg::KIND_W-1:0] r_kind;
    logic signed [VALUE_WIDTH-1:0]       r_value;
    logic        [olist_pkg::POS_W-1:0]  r_pos;
    logic        [CNT_W-1:0]             r_count;
    logic        [CNT_W-1:0]             r_ptr;
    logic signed [VALUE_WIDTH-1:0]       r_victim;

    logic                                 r_out_valid;
    logic        [olist_pkg::STATUS_W-1:0] r_out_status;
    logic signed [olist_pkg::VALUE_IN_W-1:0] r_out_value;
    logic                                 r_out_last;
    logic        [olist_pkg::ENTRIES_W-1:0] r_out_entries;

    logic        [CNT_W-1:0]             target;
    logic        [olist_pkg::POS_W-1:0]  pos_m1;
    logic        [olist_pkg::POS_CMP_W-1:0] pos_ext;
    logic        [olist_pkg::POS_CMP_W-1:0] cnt_ext;
    logic        [AW-1:0]                rd_addr;
    logic        [VALUE_WIDTH-1:0]       wr_data;
    logic        [VALUE_WIDTH-1:0]       rd_data;
    logic signed [VALUE_WIDTH-1:0]       out_src_value;
    logic                                out_free;

    assign pos_m1  = r_pos - ONE_POS;
    assign pos_ext = olist_pkg::POS_CMP_W'(r_pos);
    assign cnt_ext = olist_pkg::POS_CMP_W'(r_count);

    always_comb begin
        case (r_kind)
            olist_pkg::KIND_INS_FRONT,
            olist_pkg::KIND_DEL_FRONT: target = '0;
            olist_pkg::KIND_INS_BACK:  target = r_count;
            olist_pkg::KIND_DEL_BACK:  target = r_count - ONE_CNT;
            default:                   target = CNT_W'(pos_m1);
        endcase
    end

    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        o_stat.is_ins      = r_kind inside {olist_pkg::KIND_INS_FRONT,
                                            olist_pkg::KIND_INS_BACK,
                                            olist_pkg::KIND_INS_AT};
        o_stat.is_del      = r_kind inside {olist_pkg::KIND_DEL_FRONT,
                                            olist_pkg::KIND_DEL_BACK,
                                            olist_pkg::KIND_DEL_AT};
        o_stat.is_trav     = (r_kind == olist_pkg::KIND_TRAVERSE);
        o_stat.pos_kind    = (r_kind == olist_pkg::KIND_INS_AT) ||
                             (r_kind == olist_pkg::KIND_DEL_AT);
        o_stat.full        = (r_count == CAP_CNT);
        o_stat.empty       = (r_count == '0);
        o_stat.ins_pos_bad = (r_pos == '0) || (pos_ext > cnt_ext + ONE_CMP);
        o_stat.del_pos_bad = (r_pos == '0) || (pos_ext > cnt_ext);
        o_stat.ptr_at_tgt  = (r_ptr == target);
        o_stat.ptr_last    = ((CNT_W + 1)'(r_ptr) + (CNT_W + 1)'(1)) ==
                             (CNT_W + 1)'(r_count);
        o_stat.out_free    = out_free;
    end

    always_comb begin
        case (i_cmd.rd_sel)
            olist_pkg::RD_PTR_DEC: rd_addr = AW'(r_ptr - ONE_CNT);
            olist_pkg::RD_PTR_INC: rd_addr = AW'(r_ptr + ONE_CNT);
            default:               rd_addr = AW'(r_ptr);
        endcase
    end

    assign wr_data = (i_cmd.wr_src == olist_pkg::WR_SRC_RAM) ? rd_data : r_value;

    olist_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (AW'(r_ptr)),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        case (i_cmd.emit_src)
            olist_pkg::OUT_SRC_RAM:   out_src_value = rd_data;
            olist_pkg::OUT_SRC_SAVED: out_src_value = r_victim;
            default:                  out_src_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.cnt_op)
                olist_pkg::CNT_INC: r_count <= r_count + ONE_CNT;
                olist_pkg::CNT_DEC: r_count <= r_count - ONE_CNT;
                default:            r_count <= r_count;
            endcase
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_value <= VALUE_WIDTH'(i_value);
            r_pos   <= i_pos;
        end
        case (i_cmd.ptr_op)
            olist_pkg::PTR_ZERO:   r_ptr <= '0;
            olist_pkg::PTR_COUNT:  r_ptr <= r_count;
            olist_pkg::PTR_TARGET: r_ptr <= target;
            olist_pkg::PTR_INC:    r_ptr <= r_ptr + ONE_CNT;
            olist_pkg::PTR_DEC:    r_ptr <= r_ptr - ONE_CNT;
            default:               r_ptr <= r_ptr;
        endcase
        if (i_cmd.save_victim) begin
            r_victim <= rd_data;
        end
        if (i_cmd.emit) begin
            r_out_status  <= i_cmd.emit_status;
            r_out_value   <= (i_cmd.emit_status == olist_pkg::ST_OK) ?
                             olist_pkg::VALUE_IN_W'(out_src_value) : '0;
            r_out_last    <= i_cmd.emit_last;
            r_out_entries <= olist_pkg::ENTRIES_W'(r_count);
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_status     = r_out_status;
    assign o_item_value = r_out_value;
    assign o_last       = r_out_last;
    assign o_entries    = r_out_entries;

endmodule

`default_nettype wire

// ===== rtl/core/ordered_list_engine_top.sv =====
// ordered_list_engine_top: top level of the ordered list engine.
// Depends on olist_pkg, olist_ctrl, olist_dp (which holds olist_ram).
//
// Ordered list of up to CAPACITY signed values held packed in one
// simple dual-port RAM (no clearing pass after reset; the block is ready at
// once). One request beat is taken while the engine is idle, even if a
// result beat is still waiting on the master side. Insert at index k of a
// list of n values moves the n-k values from index k up by one; delete at
// index k saves that value and moves the n-1-k values behind it down. Each
// move in the RAM is a read, then a write. A traverse gives one beat per
// value (RAM read, then emit), held while a result beat waits. Values are
// kept at VALUE_WIDTH bits, sign-extended or truncated to 32 bits on ports.
`default_nettype none

module ordered_list_engine_top #(
    parameter int CAPACITY    = olist_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = olist_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // value [31:0], position [39:32]
    input  wire logic [olist_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // kind [2:0]
    input  wire logic [olist_pkg::KIND_W-1:0]        i_s_tuser,
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // item_value [31:0], entries [37:32], zero [39:38]
    output logic [olist_pkg::M_TDATA_W-1:0]          o_m_tdata,
    // status [1:0]
    output logic [olist_pkg::STATUS_W-1:0]           o_m_tuser,
    output logic                                     o_m_tlast
);

    olist_pkg::t_dp_cmd  cmd;
    olist_pkg::t_dp_stat stat;
    logic                ready;
    logic signed [olist_pkg::VALUE_IN_W-1:0] item_value;
    logic        [olist_pkg::ENTRIES_W-1:0]  entries;

    olist_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (i_s_tvalid && ready),
        .i_stat   (stat),
        .o_ready  (ready),
        .o_cmd    (cmd)
    );

    olist_dp #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_kind       (i_s_tuser),
        .i_value      (i_s_tdata[olist_pkg::VALUE_IN_W-1:0]),
        .i_pos        (i_s_tdata[olist_pkg::VALUE_IN_W +: olist_pkg::POS_W]),
        .i_m_tready   (i_m_tready),
        .o_stat       (stat),
        .o_m_tvalid   (o_m_tvalid),
        .o_status     (o_m_tuser),
        .o_item_value (item_value),
        .o_last       (o_m_tlast),
        .o_entries    (entries)
    );

    assign o_s_tready = ready;
    assign o_m_tdata  = {{olist_pkg::M_PAD_W{1'b0}}, entries, item_value};

endmodule

`default_nettype wire
